// ----- design/pt64_pkg.sv -----
// pt64_pkg: types and constants for the 64-bit primality test unit.
// Used by pt64_modmul and primality_test_64_unit.
package pt64_pkg;

  localparam int unsigned WordWidth  = 64;
  localparam int unsigned NumSmall   = 12;
  localparam int unsigned NumBases   = 7;
  localparam int unsigned SmallWidth = 6;

  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TRIAL,
    S_SCREEN,
    S_DECOMP,
    S_BASE,
    S_MUL,
    S_RED_DONE,
    S_POW,
    S_POW_SQ_DONE,
    S_POW_MUL_DONE,
    S_CHECK,
    S_SQ,
    S_SQ_DONE,
    S_NEXT,
    S_FINISH
  } pt_state_e;

  typedef enum logic {
    MM_DBL,
    MM_ADD
  } mm_phase_e;

  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
    word_t m;
  } mm_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } mm_rsp_t;

  function automatic logic [SmallWidth-1:0] small_prime(input logic [3:0] idx);
    logic [SmallWidth-1:0] p;
    case (idx)
      4'd0:    p = 6'd2;
      4'd1:    p = 6'd3;
      4'd2:    p = 6'd5;
      4'd3:    p = 6'd7;
      4'd4:    p = 6'd11;
      4'd5:    p = 6'd13;
      4'd6:    p = 6'd17;
      4'd7:    p = 6'd19;
      4'd8:    p = 6'd23;
      4'd9:    p = 6'd29;
      4'd10:   p = 6'd31;
      4'd11:   p = 6'd37;
      default: p = 6'd2;
    endcase
    return p;
  endfunction

  function automatic word_t mr_base(input logic [2:0] idx);
    word_t b;
    case (idx)
      3'd0:    b = 64'd2;
      3'd1:    b = 64'd325;
      3'd2:    b = 64'd9375;
      3'd3:    b = 64'd28178;
      3'd4:    b = 64'd450775;
      3'd5:    b = 64'd9780504;
      3'd6:    b = 64'd1795265022;
      default: b = 64'd2;
    endcase
    return b;
  endfunction

endpackage

// ----- design/pt64_modmul.sv -----
// pt64_modmul: bit-serial (x * y) mod m by doubling and conditional adding.
// Depends on pt64_pkg. Operands must satisfy x < m; m > 1.
module pt64_modmul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pt64_pkg::mm_req_t req_i,
  output pt64_pkg::mm_rsp_t rsp_o
);

  pt64_pkg::word_t   acc_q, acc_d, x_q, y_q, m_q;
  logic [5:0]        bit_q, bit_d;
  pt64_pkg::mm_phase_e phase_q, phase_d;
  logic              busy_q, busy_d, done_q, done_d;
  pt64_pkg::word_t   addend, room;
  logic              advance;

  // one modular add per cycle: acc + addend mod m, both below m
  always_comb begin
    addend = (phase_q == pt64_pkg::MM_ADD) ? x_q : acc_q;
    room   = m_q - addend;
    acc_d  = (acc_q >= room) ? (acc_q - room) : (acc_q + addend);
  end

  always_comb begin
    bit_d   = bit_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    advance = 1'b0;
    if (busy_q) begin
      case (phase_q)
        pt64_pkg::MM_DBL: begin
          if (y_q[bit_q]) phase_d = pt64_pkg::MM_ADD;
          else            advance = 1'b1;
        end
        pt64_pkg::MM_ADD: advance = 1'b1;
        default:          advance = 1'b1;
      endcase
      if (advance) begin
        phase_d = pt64_pkg::MM_DBL;
        if (bit_q == 6'd0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          bit_d = bit_q - 6'd1;
        end
      end
    end else if (req_i.start) begin
      busy_d  = 1'b1;
      bit_d   = 6'd63;
      phase_d = pt64_pkg::MM_DBL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      bit_q   <= 6'd0;
      phase_q <= pt64_pkg::MM_DBL;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      bit_q   <= bit_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.start) begin
      acc_q <= '0;
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      m_q   <= req_i.m;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule

// ----- design/primality_test_64_unit.sv -----
// primality_test_64_unit: deterministic 64-bit primality test (trial division
// by 2..37, then strong-probable-prime rounds for seven fixed bases).
// Depends on pt64_pkg and pt64_modmul.
//
//   channel | signals                                   | direction
//   input   | in_valid_i, in_ready_o, candidate_value_i | one candidate per transfer
//   output  | out_valid_o, out_ready_i, prime_flag_o    | one flag per transfer
//
// Steps: trial division (twelve remainder lanes in parallel), stripping powers
// of two from n-1, then per base one reduction, 64 squarings plus up to 64
// multiplies and up to s-1 further squarings, each product done in the shared
// bit-serial modular multiplier. Small-factor candidates skip the base rounds.
// Reset clears the sequencer and output valid. in_ready_o is high only while
// idle; a finished flag waits in the sequencer until the output slot is free.
module primality_test_64_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [63:0]           candidate_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  prime_flag_o
);

  pt64_pkg::pt_state_e state_q, state_d, ret_q, ret_d;
  pt64_pkg::word_t     n_q, d_q, d_d, x_q, x_d, a_q, a_d, n_minus1;
  logic [pt64_pkg::SmallWidth-1:0] rem_q [pt64_pkg::NumSmall];
  logic [pt64_pkg::SmallWidth-1:0] rem_d [pt64_pkg::NumSmall];
  logic [5:0]          cnt_q, cnt_d, s_q, s_d, r_q, r_d;
  logic [2:0]          bi_q, bi_d;
  logic                res_q, res_d;
  logic                out_valid_q, out_valid_d, flag_q, flag_d;
  logic                hit;
  logic [pt64_pkg::SmallWidth-1:0] hit_p;
  logic [pt64_pkg::SmallWidth:0]   twice;
  pt64_pkg::mm_req_t   mm_req;
  pt64_pkg::mm_rsp_t   mm_rsp;

  pt64_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  assign n_minus1 = n_q - 64'd1;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    d_d         = d_q;
    x_d         = x_q;
    a_d         = a_q;
    cnt_d       = cnt_q;
    s_d         = s_q;
    r_d         = r_q;
    bi_d        = bi_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    flag_d      = flag_q;
    mm_req      = '{start: 1'b0, x: x_q, y: x_q, m: n_q};
    hit         = 1'b0;
    hit_p       = '0;
    twice       = '0;
    for (int i = 0; i < pt64_pkg::NumSmall; i++) rem_d[i] = rem_q[i];

    // drop the result once the consumer takes it
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    // first small prime in list order that divides n
    for (int i = pt64_pkg::NumSmall - 1; i >= 0; i--) begin
      if (rem_q[i] == '0) begin
        hit   = 1'b1;
        hit_p = pt64_pkg::small_prime(4'(i));
      end
    end

    case (state_q)
      pt64_pkg::S_IDLE: begin
        if (in_valid_i) begin
          for (int i = 0; i < pt64_pkg::NumSmall; i++) rem_d[i] = '0;
          cnt_d   = 6'd63;
          state_d = pt64_pkg::S_TRIAL;
        end
      end
      // one bit of n per cycle into every remainder lane, MSB first
      pt64_pkg::S_TRIAL: begin
        for (int i = 0; i < pt64_pkg::NumSmall; i++) begin
          twice = {rem_q[i], n_q[cnt_q]};
          if (twice >= {1'b0, pt64_pkg::small_prime(4'(i))})
            twice = twice - {1'b0, pt64_pkg::small_prime(4'(i))};
          rem_d[i] = twice[pt64_pkg::SmallWidth-1:0];
        end
        if (cnt_q == 6'd0) state_d = pt64_pkg::S_SCREEN;
        else               cnt_d   = cnt_q - 6'd1;
      end
      pt64_pkg::S_SCREEN: begin
        if (n_q < 64'd2) begin
          res_d   = 1'b0;
          state_d = pt64_pkg::S_FINISH;
        end else if (hit) begin
          res_d   = (n_q == {58'd0, hit_p});
          state_d = pt64_pkg::S_FINISH;
        end else begin
          d_d     = n_minus1;
          s_d     = 6'd0;
          state_d = pt64_pkg::S_DECOMP;
        end
      end
      // n-1 = d * 2^s, one shift per cycle
      pt64_pkg::S_DECOMP: begin
        if (!d_q[0]) begin
          d_d = {1'b0, d_q[63:1]};
          s_d = s_q + 6'd1;
        end else begin
          bi_d    = 3'd0;
          state_d = pt64_pkg::S_BASE;
        end
      end
      // base mod n as 1 * base mod n
      pt64_pkg::S_BASE: begin
        mm_req  = '{start: 1'b1, x: 64'd1, y: pt64_pkg::mr_base(bi_q), m: n_q};
        ret_d   = pt64_pkg::S_RED_DONE;
        state_d = pt64_pkg::S_MUL;
      end
      // hold until the shared multiplier finishes, then return
      pt64_pkg::S_MUL: begin
        if (mm_rsp.done) begin
          x_d     = mm_rsp.result;
          state_d = ret_q;
        end
      end
      pt64_pkg::S_RED_DONE: begin
        a_d = x_q;
        if (x_q == '0) begin
          state_d = pt64_pkg::S_NEXT;
        end else begin
          x_d     = 64'd1;
          cnt_d   = 6'd63;
          state_d = pt64_pkg::S_POW;
        end
      end
      // left-to-right square and multiply over the bits of d
      pt64_pkg::S_POW: begin
        mm_req  = '{start: 1'b1, x: x_q, y: x_q, m: n_q};
        ret_d   = pt64_pkg::S_POW_SQ_DONE;
        state_d = pt64_pkg::S_MUL;
      end
      pt64_pkg::S_POW_SQ_DONE: begin
        if (d_q[cnt_q]) begin
          mm_req  = '{start: 1'b1, x: a_q, y: x_q, m: n_q};
          ret_d   = pt64_pkg::S_POW_MUL_DONE;
          state_d = pt64_pkg::S_MUL;
        end else begin
          state_d = pt64_pkg::S_POW_MUL_DONE;
        end
      end
      pt64_pkg::S_POW_MUL_DONE: begin
        if (cnt_q == 6'd0) begin
          state_d = pt64_pkg::S_CHECK;
        end else begin
          cnt_d   = cnt_q - 6'd1;
          state_d = pt64_pkg::S_POW;
        end
      end
      pt64_pkg::S_CHECK: begin
        r_d = 6'd1;
        if (x_q == 64'd1 || x_q == n_minus1) state_d = pt64_pkg::S_NEXT;
        else                                 state_d = pt64_pkg::S_SQ;
      end
      pt64_pkg::S_SQ: begin
        if (r_q < s_q) begin
          mm_req  = '{start: 1'b1, x: x_q, y: x_q, m: n_q};
          ret_d   = pt64_pkg::S_SQ_DONE;
          state_d = pt64_pkg::S_MUL;
        end else begin
          res_d   = 1'b0;
          state_d = pt64_pkg::S_FINISH;
        end
      end
      pt64_pkg::S_SQ_DONE: begin
        if (x_q == n_minus1) begin
          state_d = pt64_pkg::S_NEXT;
        end else begin
          r_d     = r_q + 6'd1;
          state_d = pt64_pkg::S_SQ;
        end
      end
      pt64_pkg::S_NEXT: begin
        if (bi_q == 3'(pt64_pkg::NumBases - 1)) begin
          res_d   = 1'b1;
          state_d = pt64_pkg::S_FINISH;
        end else begin
          bi_d    = bi_q + 3'd1;
          state_d = pt64_pkg::S_BASE;
        end
      end
      // advance the flag into the output slot once it is free
      pt64_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          flag_d      = res_q;
          state_d     = pt64_pkg::S_IDLE;
        end
      end
      default: state_d = pt64_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pt64_pkg::S_IDLE;
      ret_q       <= pt64_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pt64_pkg::S_IDLE && in_valid_i) n_q <= candidate_value_i;
    d_q    <= d_d;
    x_q    <= x_d;
    a_q    <= a_d;
    cnt_q  <= cnt_d;
    s_q    <= s_d;
    r_q    <= r_d;
    bi_q   <= bi_d;
    res_q  <= res_d;
    flag_q <= flag_d;
    for (int i = 0; i < pt64_pkg::NumSmall; i++) rem_q[i] <= rem_d[i];
  end

  assign in_ready_o   = (state_q == pt64_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign prime_flag_o = flag_q;

endmodule

// ----- design/pt64_checker.sv -----
// pt64_checker: port-level assertions for primality_test_64_unit.
// Depends on primality_test_64_unit; attached by the bind below.
module pt64_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic prime_flag_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(prime_flag_o))
    else $error("result dropped or changed while stalled");

  // busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // trial division comes first, so an input transfer never raises the result valid at once
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after input");

endmodule

bind primality_test_64_unit pt64_checker u_pt64_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .prime_flag_o (prime_flag_o)
);
